/* sv/fqr_pkg.sv */
// ----------------------------------------------------------------------------
// fqr_pkg
// Types and constants shared by the queue with in-place reverse.
// ----------------------------------------------------------------------------
package fqr_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register index taken from the word address bit
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 4'd8;

  typedef enum logic [1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_PEEK = 2'd2,
    MODE_REV  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REV_RD_A,
    ST_REV_RD_B,
    ST_REV_WR_A,
    ST_REV_WR_B,
    ST_RESP
  } state_t;

  // command to the entry store
  typedef struct packed {
    logic we;
    logic re;
  } mem_cmd_t;

endpackage

/* sv/fqr_store.sv */
// ----------------------------------------------------------------------------
// fqr_store
// Entry store: one shared address, one write or one registered read a cycle.
// ----------------------------------------------------------------------------
module fqr_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                      clk,
  input  fqr_pkg::mem_cmd_t         cmd,
  input  logic [AW-1:0]             addr,
  input  logic [fqr_pkg::DATA_W-1:0] wdata,
  output logic [fqr_pkg::DATA_W-1:0] rdata
);

  logic [fqr_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* sv/fqr_slot.sv */
// ----------------------------------------------------------------------------
// fqr_slot
// Shared address unit: position of the entry at an offset from the head,
// wrapped round the store.
// ----------------------------------------------------------------------------
module fqr_slot #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic [AW-1:0]              head,
  input  logic [fqr_pkg::COUNT_W-1:0] offset,
  output logic [AW-1:0]              slot
);

  localparam int SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  logic [SW-1:0] sum;

  // offset never exceeds the depth, so one compare and subtract wraps it
  assign sum  = {1'b0, head} + SW'(offset);
  assign slot = (sum >= DEPTH_S) ? AW'(sum - DEPTH_S) : AW'(sum);

endmodule

/* sv/fifo_queue_with_reverse.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_reverse
// Bounded queue of signed 32-bit words with enqueue, dequeue, peek and an
// in-place reverse of the held entries, under a small sequencer.
//
//   channel  signals                               role
//   in       in_valid, in_ready, mode, data_in     one request per word
//   out      out_valid, out_ready, status,
//            data_out, item_count                  one result per request
//   cfg      psel, penable, pwrite, paddr,
//            pwdata, prdata, pready                capacity register
//
// Enqueue, dequeue, peek, rejected requests and a reverse of one entry hold
// the sequencer through the accept cycle and the result load; reverse of
// n > 1 entries also holds it while pairs are swapped from both ends, one memory access a
// cycle through the single port of the entry store.
// in_ready is high only while the sequencer is idle; a result waiting in the
// output register stalls the next result load and with it the next accept.
// rst is synchronous: queue empty, head at zero, capacity 8.
// ----------------------------------------------------------------------------
module fifo_queue_with_reverse #(
  parameter int DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        mode,
  input  logic signed [fqr_pkg::DATA_W-1:0] data_in,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [fqr_pkg::DATA_W-1:0] data_out,
  output logic [fqr_pkg::COUNT_W-1:0]       item_count,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fqr_pkg::PADDR_W-1:0]       paddr,
  input  logic [fqr_pkg::PDATA_W-1:0]       pwdata,
  output logic [fqr_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_MAX = (DEPTH > 15) ? 15 : DEPTH;
  localparam logic [fqr_pkg::COUNT_W-1:0] CAP_MAX_W = fqr_pkg::COUNT_W'(CAP_MAX);

  fqr_pkg::state_t  state, state_next;
  fqr_pkg::mode_t   req_mode;
  fqr_pkg::mode_t   in_mode;
  fqr_pkg::status_t req_status;
  fqr_pkg::status_t acc_status;
  fqr_pkg::mem_cmd_t mem_cmd;

  logic [fqr_pkg::COUNT_W-1:0] capacity;
  logic [fqr_pkg::COUNT_W-1:0] cap_lim;
  logic [fqr_pkg::COUNT_W-1:0] count;
  logic [fqr_pkg::COUNT_W-1:0] lo, hi;
  logic [fqr_pkg::COUNT_W-1:0] offset;
  logic [AW-1:0]               head;
  logic [AW-1:0]               slot;
  logic [fqr_pkg::DATA_W-1:0]  wdata, rdata, tmp;
  logic                        accept;
  logic                        cfg_wr;
  logic                        res_load;
  logic                        take_data;
  logic                        deq_ok;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == fqr_pkg::REG_CAPACITY) ?
                  fqr_pkg::PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= fqr_pkg::CAPACITY_RESET;
    end else if (cfg_wr && paddr[2] == fqr_pkg::REG_CAPACITY) begin
      capacity <= pwdata[fqr_pkg::COUNT_W-1:0];
    end
  end

  assign cap_lim = (capacity > CAP_MAX_W) ? CAP_MAX_W : capacity;

  // ---------------------------------------------------------------- datapath
  assign in_mode  = fqr_pkg::mode_t'(mode);
  assign in_ready = (state == fqr_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign res_load = (state == fqr_pkg::ST_RESP) && (!out_valid || out_ready);
  assign take_data = (req_status == fqr_pkg::STAT_OK) &&
                     (req_mode == fqr_pkg::MODE_DEQ || req_mode == fqr_pkg::MODE_PEEK);
  assign deq_ok   = (req_status == fqr_pkg::STAT_OK) && (req_mode == fqr_pkg::MODE_DEQ);

  always_comb begin
    if (in_mode == fqr_pkg::MODE_ENQ) begin
      acc_status = (count >= cap_lim) ? fqr_pkg::STAT_FULL : fqr_pkg::STAT_OK;
    end else if (count == '0) begin
      acc_status = fqr_pkg::STAT_EMPTY;
    end else begin
      acc_status = fqr_pkg::STAT_OK;
    end
  end

  fqr_slot #(.DEPTH(DEPTH), .AW(AW)) u_slot (
    .head   (head),
    .offset (offset),
    .slot   (slot)
  );

  fqr_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (slot),
    .wdata (wdata),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fqr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    offset     = '0;
    mem_cmd    = '{we: 1'b0, re: 1'b0};
    wdata      = data_in;
    case (state)
      fqr_pkg::ST_IDLE: begin
        // enqueue writes at the tail, anything else reads the oldest word
        offset = (in_mode == fqr_pkg::MODE_ENQ) ? count : '0;
        if (accept) begin
          mem_cmd.we = (in_mode == fqr_pkg::MODE_ENQ) &&
                       (acc_status == fqr_pkg::STAT_OK);
          mem_cmd.re = (in_mode != fqr_pkg::MODE_ENQ);
          if (in_mode == fqr_pkg::MODE_REV && count > 4'd1) begin
            state_next = fqr_pkg::ST_REV_RD_B;
          end else begin
            state_next = fqr_pkg::ST_RESP;
          end
        end
      end
      fqr_pkg::ST_REV_RD_A: begin
        offset     = lo;
        mem_cmd.re = 1'b1;
        state_next = fqr_pkg::ST_REV_RD_B;
      end
      fqr_pkg::ST_REV_RD_B: begin
        offset     = hi;
        mem_cmd.re = 1'b1;
        state_next = fqr_pkg::ST_REV_WR_A;
      end
      fqr_pkg::ST_REV_WR_A: begin
        offset     = lo;
        mem_cmd.we = 1'b1;
        wdata      = rdata;
        state_next = fqr_pkg::ST_REV_WR_B;
      end
      fqr_pkg::ST_REV_WR_B: begin
        offset     = hi;
        mem_cmd.we = 1'b1;
        wdata      = tmp;
        // more swaps while the pointers have not met
        if (fqr_pkg::COUNT_W'(lo + 4'd2) < hi) begin
          state_next = fqr_pkg::ST_REV_RD_A;
        end else begin
          state_next = fqr_pkg::ST_RESP;
        end
      end
      fqr_pkg::ST_RESP: begin
        // next head for a dequeue
        offset = 4'd1;
        if (res_load) begin
          state_next = fqr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fqr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
    end else begin
      if (accept && in_mode == fqr_pkg::MODE_ENQ && acc_status == fqr_pkg::STAT_OK) begin
        count <= count + 4'd1;
      end else if (res_load && deq_ok) begin
        count <= count - 4'd1;
        head  <= slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode   <= in_mode;
      req_status <= acc_status;
      lo         <= '0;
      hi         <= count - 4'd1;
    end
    if (state == fqr_pkg::ST_REV_RD_B) begin
      tmp <= rdata;
    end
    if (state == fqr_pkg::ST_REV_WR_B) begin
      lo <= lo + 4'd1;
      hi <= hi - 4'd1;
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status     <= req_status;
      data_out   <= take_data ? rdata : '0;
      item_count <= deq_ok ? count - 4'd1 : count;
    end
  end

endmodule

/* tb/fqr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqr_checker
// Watches the request, result and register ports of the queue, keeps its own
// copy of the queue and the capacity, and compares every result word, field
// by field, with the prediction for the oldest outstanding request.
// ----------------------------------------------------------------------------
module fqr_checker #(
  parameter int DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [1:0]                         mode,
  input  logic signed [fqr_pkg::DATA_W-1:0]  data_in,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [1:0]                         status,
  input  logic signed [fqr_pkg::DATA_W-1:0]  data_out,
  input  logic [fqr_pkg::COUNT_W-1:0]        item_count,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fqr_pkg::PADDR_W-1:0]        paddr,
  input  logic [fqr_pkg::PDATA_W-1:0]        pwdata,
  input  logic [fqr_pkg::PDATA_W-1:0]        prdata,
  input  logic                               pready,
  output int                                 fail_count,
  output int                                 pending
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [fqr_pkg::PADDR_W-1:0] CAPACITY_ADDR = {fqr_pkg::REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic [1:0]                        status;
    logic signed [fqr_pkg::DATA_W-1:0] value;
    logic [fqr_pkg::COUNT_W-1:0]       count;
  } queue_resp_t;

  logic [fqr_pkg::DATA_W-1:0]  entries [DEPTH];
  logic [IDX_W-1:0]            head;
  logic [fqr_pkg::COUNT_W-1:0] held;
  logic [fqr_pkg::COUNT_W-1:0] capacity;
  queue_resp_t                 expected_results [$];
  int                          errors = 0;

  assign fail_count = errors;
  assign pending    = expected_results.size();

  function automatic logic [IDX_W-1:0] slot_of(int unsigned offset);
    return IDX_W'((head + offset) % DEPTH);
  endfunction

  // advances the queue copy by one request and returns the result it gives
  function automatic queue_resp_t apply_request(fqr_pkg::mode_t op,
                                                logic [fqr_pkg::DATA_W-1:0] word);
    queue_resp_t                r;
    int unsigned                limit;
    int unsigned                lo;
    int unsigned                hi;
    logic [fqr_pkg::DATA_W-1:0] tmp;
    r.status = fqr_pkg::STAT_OK;
    r.value  = '0;
    limit    = (capacity > DEPTH) ? DEPTH : capacity;
    if (op == fqr_pkg::MODE_ENQ) begin
      if (held >= limit) begin
        r.status = fqr_pkg::STAT_FULL;
      end else begin
        entries[slot_of(held)] = word;
        held = held + 1'b1;
      end
    end else if (held == 0) begin
      r.status = fqr_pkg::STAT_EMPTY;
    end else if (op == fqr_pkg::MODE_DEQ) begin
      r.value = entries[slot_of(0)];
      head    = slot_of(1);
      held    = held - 1'b1;
    end else if (op == fqr_pkg::MODE_PEEK) begin
      r.value = entries[slot_of(0)];
    end else begin
      // swap pairs from both ends of the held span
      lo = 0;
      hi = held - 1;
      while (lo < hi) begin
        tmp                 = entries[slot_of(lo)];
        entries[slot_of(lo)] = entries[slot_of(hi)];
        entries[slot_of(hi)] = tmp;
        lo++;
        hi--;
      end
    end
    r.count = held;
    return r;
  endfunction

  always @(posedge clk) begin
    queue_resp_t want;
    if (rst) begin
      head     = '0;
      held     = '0;
      capacity = fqr_pkg::CAPACITY_RESET;
      expected_results.delete();
    end else begin
      if (psel && penable && pready && paddr == CAPACITY_ADDR) begin
        if (pwrite) begin
          capacity = pwdata[fqr_pkg::COUNT_W-1:0];
        end else if (prdata !== fqr_pkg::PDATA_W'(capacity)) begin
          $error("prdata: expected %0d, got %0d", capacity, prdata);
          errors++;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no request outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          if (data_out !== want.value) begin
            $error("data_out: expected %0d, got %0d", want.value, data_out);
            errors++;
          end
          if (item_count !== want.count) begin
            $error("item_count: expected %0d, got %0d", want.count, item_count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_request(fqr_pkg::mode_t'(mode), data_in));
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the queue with a directed opening (empty and full rejections,
// extreme words, peek, reverse of many and of one entry) and then phases of
// random requests, each under a capacity from a plan, with random gaps on the
// request side and random back-pressure on the result side except in steady phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 50;
  localparam logic [fqr_pkg::PADDR_W-1:0] CAPACITY_ADDR = {fqr_pkg::REG_CAPACITY, 2'b00};
  // zero, above depth and lowered below the held count all come up here
  localparam logic [fqr_pkg::COUNT_W-1:0] CAP_PLAN [PHASES] =
    '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd9, 4'd5, 4'd3, 4'd8, 4'd6, 4'd7, 4'd4};

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              in_valid  = 1'b0;
  logic [1:0]                        mode      = fqr_pkg::MODE_ENQ;
  logic signed [fqr_pkg::DATA_W-1:0] data_in   = '0;
  logic                              out_ready = 1'b0;
  logic                              psel      = 1'b0;
  logic                              penable   = 1'b0;
  logic                              pwrite    = 1'b0;
  logic [fqr_pkg::PADDR_W-1:0]       paddr     = '0;
  logic [fqr_pkg::PDATA_W-1:0]       pwdata    = '0;
  logic                              in_ready;
  logic                              out_valid;
  logic [1:0]                        status;
  logic signed [fqr_pkg::DATA_W-1:0] data_out;
  logic [fqr_pkg::COUNT_W-1:0]       item_count;
  logic [fqr_pkg::PDATA_W-1:0]       prdata;
  logic                              pready;
  int                                fail_count;
  int                                pending;
  int                                idle_cycles = 0;
  int                                stall_left  = 0;
  logic                              steady      = 1'b0;

  always #5 clk = ~clk;

  fifo_queue_with_reverse #(.DEPTH(8)) dut (.*);

  fqr_checker #(.DEPTH(8)) u_result_check (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    else if (r < 94) return $urandom_range(3, 1);
    else return $urandom_range(30, 8);
  endfunction

  // lean 1 favours enqueue, lean 2 favours dequeue
  function automatic fqr_pkg::mode_t pick_mode(int lean);
    int r;
    int enq_cut;
    int deq_cut;
    r = $urandom_range(99);
    enq_cut = (lean == 1) ? 60 : (lean == 2) ? 25 : 40;
    deq_cut = (lean == 1) ? 75 : 70;
    if (r < enq_cut) return fqr_pkg::MODE_ENQ;
    else if (r < deq_cut) return fqr_pkg::MODE_DEQ;
    else if (r < 86) return fqr_pkg::MODE_PEEK;
    else return fqr_pkg::MODE_REV;
  endfunction

  function automatic logic [fqr_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(15))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // result-side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(fqr_pkg::mode_t op, logic [fqr_pkg::DATA_W-1:0] word);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    data_in  <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  // only called with the request side idle; writes then reads back
  task automatic write_capacity(logic [fqr_pkg::COUNT_W-1:0] value);
    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= fqr_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int p;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // rejections on an empty queue
    send_request(fqr_pkg::MODE_DEQ, pick_word());
    send_request(fqr_pkg::MODE_PEEK, pick_word());
    send_request(fqr_pkg::MODE_REV, pick_word());
    // fill to the reset capacity with extreme words, then one too many
    send_request(fqr_pkg::MODE_ENQ, 32'h7fff_ffff);
    send_request(fqr_pkg::MODE_ENQ, 32'h8000_0000);
    send_request(fqr_pkg::MODE_ENQ, '0);
    send_request(fqr_pkg::MODE_ENQ, '1);
    send_request(fqr_pkg::MODE_ENQ, 32'd1);
    repeat (3) send_request(fqr_pkg::MODE_ENQ, $urandom());
    send_request(fqr_pkg::MODE_ENQ, 32'h55aa_55aa);
    send_request(fqr_pkg::MODE_PEEK, pick_word());
    send_request(fqr_pkg::MODE_REV, pick_word());
    send_request(fqr_pkg::MODE_PEEK, pick_word());
    send_request(fqr_pkg::MODE_DEQ, pick_word());
    send_request(fqr_pkg::MODE_DEQ, pick_word());
    send_request(fqr_pkg::MODE_REV, pick_word());
    repeat (5) send_request(fqr_pkg::MODE_DEQ, pick_word());
    // reverse with a single word held
    send_request(fqr_pkg::MODE_REV, pick_word());
    send_request(fqr_pkg::MODE_DEQ, pick_word());

    for (p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      write_capacity(CAP_PLAN[p]);
      steady <= (p % 4 == 3);
      repeat (PHASE_ITEMS) send_request(pick_mode(p % 3), pick_word());
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
